FILE: rtl/ftat_pkg.sv
// Shared types, constants and the product scaling function for the
// feature threshold autotuner. No dependencies.
package ftat_pkg;

	// Field and datapath widths
	localparam int THR_W    = 32;
	localparam int RATIO_W  = 16;
	localparam int CNT_W    = 16;
	localparam int ATT_W    = 4;
	localparam int VAR_W    = 2;
	localparam int VERD_W   = 2;
	localparam int IDX_W    = 3;
	localparam int WIN_W    = 10;
	localparam int PROD_W   = THR_W + RATIO_W;
	localparam int DIVD_W   = RATIO_W + WIN_W;
	localparam int MSTEP_W  = $clog2(RATIO_W + 1);

	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [RATIO_W-1:0] ratio_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [ATT_W-1:0]   att_t;
	typedef logic [VAR_W-1:0]   var_t;
	typedef logic [VERD_W-1:0]  verd_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [WIN_W-1:0]   win_t;
	typedef logic [PROD_W-1:0]  prod_t;
	typedef logic [DIVD_W-1:0]  divd_t;

	// Register indexes
	localparam idx_t REG_VARIANT = 3'd0;
	localparam idx_t REG_MIN     = 3'd1;
	localparam idx_t REG_MAX     = 3'd2;
	localparam idx_t REG_FLOOR   = 3'd3;
	localparam idx_t REG_START   = 3'd4;
	localparam idx_t REG_CEIL    = 3'd5;
	localparam idx_t REG_RAISE   = 3'd6;
	localparam idx_t REG_LOWER   = 3'd7;

	// Detector variants
	localparam var_t VAR_TRUNC = 2'd0;
	localparam var_t VAR_FRAC  = 2'd1;
	localparam var_t VAR_ROUND = 2'd2;
	localparam var_t VAR_SPARE = 2'd3;

	// Verdict codes
	localparam verd_t VERD_IN_RANGE = 2'd0;
	localparam verd_t VERD_TOO_FEW  = 2'd1;
	localparam verd_t VERD_TOO_MANY = 2'd2;
	localparam verd_t VERD_SPARE    = 2'd3;

	// Reset values
	localparam var_t   RST_VARIANT = VAR_TRUNC;
	localparam count_t RST_MIN     = 16'd1000;
	localparam count_t RST_MAX     = 16'd5000;
	localparam thr_t   RST_FLOOR   = 32'd655360;
	localparam thr_t   RST_START   = 32'd5898240;
	localparam thr_t   RST_CEIL    = 32'd7208960;
	localparam ratio_t RST_RAISE   = 16'd20480;
	localparam ratio_t RST_LOWER   = 16'd13107;

	localparam int RETRY_LIMIT_DEF = 5;

	// Ratio 1.0 in Q2.14 and the near-bound windows
	localparam ratio_t ONE_Q14      = 16'd16384;
	localparam win_t   WIN_TOO_MANY = 10'd500;
	localparam win_t   WIN_TOO_FEW  = 10'd1000;

	// Saturation values
	localparam thr_t SAT_INT  = 32'hFFFF_0000;
	localparam thr_t SAT_FRAC = 32'hFFFF_FFFF;

	// Q18.30 product to Q16.16 threshold per variant, saturating
	function automatic thr_t scale_thr(prod_t p, var_t v);
		logic [19:0] rnd;
		thr_t res;
		rnd = {1'b0, p[PROD_W-1:29]} + 20'd1;
		priority if (v == VAR_FRAC) begin
			res = (p[PROD_W-1:PROD_W-2] != 2'b00) ? SAT_FRAC : p[PROD_W-3:14];
		end else if (v == VAR_ROUND) begin
			res = (rnd[19:17] != 3'b000) ? SAT_INT : {rnd[16:1], 16'h0000};
		end else begin
			res = (p[PROD_W-1:PROD_W-2] != 2'b00) ? SAT_INT : {p[PROD_W-3:30], 16'h0000};
		end
		return res;
	endfunction

endpackage

FILE: rtl/ftat_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle (threshold x ratio).
// Depends on ftat_pkg.
module ftat_serial_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  ftat_pkg::thr_t   a,
	input  ftat_pkg::ratio_t b,
	output ftat_pkg::prod_t  prod,
	output logic             done
);
	import ftat_pkg::*;

	thr_t               a_q;
	ratio_t             b_sr_q;
	prod_t              acc_q;
	logic [MSTEP_W-1:0] step_q;
	logic               done_q;
	logic [THR_W:0]     sum;

	// Add the multiplicand into the top half when the current bit is set
	always_comb begin
		sum = {1'b0, acc_q[PROD_W-1:RATIO_W]} + (b_sr_q[0] ? {1'b0, a_q} : '0);
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			step_q <= MSTEP_W'(RATIO_W);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			done_q <= (step_q == MSTEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			b_sr_q <= b;
			acc_q  <= '0;
		end else if (step_q != '0) begin
			b_sr_q <= {1'b0, b_sr_q[RATIO_W-1:1]};
			acc_q  <= {sum, acc_q[RATIO_W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

FILE: rtl/ftat_serial_div.sv
// Restoring divider, one quotient bit per cycle, for the near-bound ratio.
// Depends on ftat_pkg. Needs dividend < divisor * 2^16.
module ftat_serial_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  ftat_pkg::divd_t  dividend,
	input  ftat_pkg::win_t   divisor,
	output ftat_pkg::ratio_t quotient,
	output logic             done
);
	import ftat_pkg::*;

	win_t               rem_q;
	win_t               dvs_q;
	ratio_t             sr_q;
	logic [MSTEP_W-1:0] step_q;
	logic               done_q;
	logic [WIN_W:0]     trial;
	logic [WIN_W:0]     diff;
	logic               ge;

	// Bring down the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, sr_q[RATIO_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			step_q <= MSTEP_W'(RATIO_W);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			done_q <= (step_q == MSTEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= dividend[DIVD_W-1:RATIO_W];
			sr_q  <= dividend[RATIO_W-1:0];
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
			sr_q  <= {sr_q[RATIO_W-2:0], ge};
		end
	end

	assign quotient = sr_q;
	assign done     = done_q;

endmodule

FILE: rtl/feature_threshold_autotune.sv
// Path from the accepted count to result valid: a count in range goes straight to the result;
// variants 0 and 1 run the threshold multiply; variant 2 runs it too outside its window, and
// inside it a 16-step multiply, a 16-step divide, then the 16-step threshold multiply.
// A new count is taken only once the previous one has reached the output register; a ready
// result waits while the output register is still stalled, and the input stalls with it.
// Reset (async, active low) loads the default registers, threshold = start, attempt = 0.
module feature_threshold_autotune #(
	parameter int RETRY_LIMIT = ftat_pkg::RETRY_LIMIT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  ftat_pkg::idx_t   cfg_index,
	input  ftat_pkg::thr_t   cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  ftat_pkg::count_t keypoint_count,
	output logic             out_valid,
	input  logic             out_stall,
	output ftat_pkg::thr_t   next_threshold,
	output ftat_pkg::verd_t  verdict,
	output logic             finished,
	output ftat_pkg::att_t   attempt_index
);
	import ftat_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PREP = 7'b0000010,
		S_NMUL = 7'b0000100,
		S_NDIV = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_POST = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers
	var_t   variant_q;
	count_t min_q;
	count_t max_q;
	thr_t   floor_q;
	thr_t   ceil_q;
	ratio_t raise_q;
	ratio_t lower_q;

	// Working state
	thr_t   thr_q;
	att_t   attempt_q;
	count_t count_q;
	verd_t  verd_q;
	var_t   var_q;
	ratio_t ratio_q;
	logic   neg_q;
	win_t   win_q;
	thr_t   scaled_q;

	// Unit operands
	logic   mul_go_q;
	thr_t   mul_a_q;
	ratio_t mul_b_q;
	logic   div_go_q;
	prod_t  mul_prod;
	logic   mul_done;
	ratio_t div_quot;
	logic   div_done;

	// Output register
	logic   out_valid_q;
	thr_t   out_thr_q;
	verd_t  out_verd_q;
	logic   out_fin_q;
	att_t   out_att_q;

	logic      accept;
	verd_t     verd_in;
	var_t      var_in;
	ratio_t    ratio_in;
	count_t    bound;
	win_t      win;
	logic [CNT_W:0] diff;
	logic [CNT_W:0] neg_diff;
	count_t    gap;
	logic      in_win;
	win_t      k;
	logic      above_one;
	ratio_t    mag;
	ratio_t    adj_ratio;
	thr_t      clamped;
	thr_t      next_thr;
	logic [ATT_W:0] att_inc;
	logic      fin;
	logic      out_free;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Classify the incoming count
	always_comb begin
		priority if (keypoint_count < min_q) begin
			verd_in = VERD_TOO_FEW;
		end else if (keypoint_count > max_q) begin
			verd_in = VERD_TOO_MANY;
		end else begin
			verd_in = VERD_IN_RANGE;
		end
		var_in   = (variant_q == VAR_SPARE) ? VAR_TRUNC : variant_q;
		ratio_in = (verd_in == VERD_TOO_FEW) ? lower_q : raise_q;
	end

	// Near-bound ratio setup: distance to the far bound, window and |1 - r|
	always_comb begin
		bound     = (verd_q == VERD_TOO_FEW) ? max_q : min_q;
		win       = (verd_q == VERD_TOO_FEW) ? WIN_TOO_FEW : WIN_TOO_MANY;
		diff      = {1'b0, count_q} - {1'b0, bound};
		neg_diff  = '0 - diff;
		gap       = diff[CNT_W] ? neg_diff[CNT_W-1:0] : diff[CNT_W-1:0];
		in_win    = (gap < {{(CNT_W-WIN_W){1'b0}}, win});
		k         = win - gap[WIN_W-1:0];
		above_one = (ratio_q > ONE_Q14);
		mag       = above_one ? (ratio_q - ONE_Q14) : (ONE_Q14 - ratio_q);
		adj_ratio = neg_q ? (ratio_q - div_quot) : (ratio_q + div_quot);
	end

	// One-sided clamp, next threshold and retry bookkeeping
	always_comb begin
		if (verd_q == VERD_TOO_FEW) begin
			clamped = (scaled_q < floor_q) ? floor_q : scaled_q;
		end else begin
			clamped = (scaled_q > ceil_q) ? ceil_q : scaled_q;
		end
		next_thr = (verd_q == VERD_IN_RANGE) ? thr_q : clamped;
		att_inc  = {1'b0, attempt_q} + (ATT_W+1)'(1);
		fin      = (verd_q == VERD_IN_RANGE) || (att_inc >= (ATT_W+1)'(RETRY_LIMIT));
	end

	// Configuration writes; threshold_start also reloads the threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= RST_VARIANT;
			min_q     <= RST_MIN;
			max_q     <= RST_MAX;
			floor_q   <= RST_FLOOR;
			ceil_q    <= RST_CEIL;
			raise_q   <= RST_RAISE;
			lower_q   <= RST_LOWER;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VARIANT: variant_q <= cfg_data[VAR_W-1:0];
				REG_MIN:     min_q     <= cfg_data[CNT_W-1:0];
				REG_MAX:     max_q     <= cfg_data[CNT_W-1:0];
				REG_FLOOR:   floor_q   <= cfg_data;
				REG_START:   ;
				REG_CEIL:    ceil_q    <= cfg_data;
				REG_RAISE:   raise_q   <= cfg_data[RATIO_W-1:0];
				REG_LOWER:   lower_q   <= cfg_data[RATIO_W-1:0];
				default:     ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= RST_START;
			attempt_q   <= '0;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en && (cfg_index == REG_START)) begin
				thr_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (verd_in == VERD_IN_RANGE) begin
							state_q <= S_DONE;
						end else if (var_in == VAR_ROUND) begin
							state_q <= S_PREP;
						end else begin
							mul_go_q <= 1'b1;
							state_q  <= S_MUL;
						end
					end
				end
				S_PREP: begin
					mul_go_q <= 1'b1;
					state_q  <= in_win ? S_NMUL : S_MUL;
				end
				S_NMUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						thr_q       <= next_thr;
						attempt_q   <= fin ? '0 : att_inc[ATT_W-1:0];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and unit operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					count_q <= keypoint_count;
					verd_q  <= verd_in;
					var_q   <= var_in;
					ratio_q <= ratio_in;
					mul_a_q <= thr_q;
					mul_b_q <= ratio_in;
				end
			end
			S_PREP: begin
				neg_q <= above_one;
				win_q <= win;
				if (in_win) begin
					mul_a_q <= {{(THR_W-RATIO_W){1'b0}}, mag};
					mul_b_q <= {{(RATIO_W-WIN_W){1'b0}}, k};
				end
			end
			S_NDIV: begin
				if (div_done) begin
					mul_a_q <= thr_q;
					mul_b_q <= adj_ratio;
				end
			end
			S_POST: begin
				scaled_q <= scale_thr(mul_prod, var_q);
			end
			S_DONE: begin
				if (out_free) begin
					out_thr_q  <= next_thr;
					out_verd_q <= verd_q;
					out_fin_q  <= fin;
					out_att_q  <= attempt_q;
				end
			end
			default: ;
		endcase
	end

	ftat_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	ftat_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (mul_prod[DIVD_W-1:0]),
		.divisor  (win_q),
		.quotient (div_quot),
		.done     (div_done)
	);

	assign out_valid      = out_valid_q;
	assign next_threshold = out_thr_q;
	assign verdict        = out_verd_q;
	assign finished       = out_fin_q;
	assign attempt_index  = out_att_q;

	// Checks
	a_att_range: assert property (@(posedge clk) disable iff (!arst_n)
		attempt_q < ATT_W'(RETRY_LIMIT))
		else $error("attempt counter beyond retry limit");

	a_in_range_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_verd_q != VERD_IN_RANGE || out_fin_q))
		else $error("in-range beat not marked finished");

	a_verd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_verd_q != VERD_SPARE))
		else $error("unused verdict code on output");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second beat taken while busy");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL || state_q == S_NMUL))
		else $error("multiplier finished outside a wait state");

endmodule

FILE: tb/tb_feature_threshold_autotune.sv
// Self-checking testbench for feature_threshold_autotune: a directed set of counts and
// register settings, then random phases, each result checked against a local predictor.
// Depends on ftat_pkg and the feature_threshold_autotune RTL.
module tb_feature_threshold_autotune;
	import ftat_pkg::*;

	localparam int RETRY_LIMIT = RETRY_LIMIT_DEF;
	localparam int LONG_HOLD   = 60;
	localparam int MAX_SHOWN   = 40;

	typedef struct packed {
		thr_t  thr;
		verd_t verd;
		logic  fin;
		att_t  idx;
	} attempt_result_t;

	typedef struct {
		var_t   variant;
		count_t min_cnt;
		count_t max_cnt;
		thr_t   floor_thr;
		thr_t   start_thr;
		thr_t   ceil_thr;
		ratio_t raise_r;
		ratio_t lower_r;
	} tune_setting_t;

	// Tracks the tuner registers and state, predicts each attempt, checks results
	class threshold_scoreboard;
		var_t   variant;
		count_t min_cnt;
		count_t max_cnt;
		thr_t   floor_thr;
		thr_t   start_thr;
		thr_t   ceil_thr;
		ratio_t raise_r;
		ratio_t lower_r;
		thr_t   cur_thr;
		att_t   attempt;
		attempt_result_t pending_results[$];
		int     errors;

		function new();
			variant   = RST_VARIANT;
			min_cnt   = RST_MIN;
			max_cnt   = RST_MAX;
			floor_thr = RST_FLOOR;
			start_thr = RST_START;
			ceil_thr  = RST_CEIL;
			raise_r   = RST_RAISE;
			lower_r   = RST_LOWER;
			cur_thr   = RST_START;
			attempt   = '0;
			errors    = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		function void write_reg(idx_t idx, thr_t data);
			case (idx)
				REG_VARIANT: variant = data[VAR_W-1:0];
				REG_MIN:     min_cnt = data[CNT_W-1:0];
				REG_MAX:     max_cnt = data[CNT_W-1:0];
				REG_FLOOR:   floor_thr = data;
				REG_START: begin
					start_thr = data;
					cur_thr   = data;
				end
				REG_CEIL:    ceil_thr = data;
				REG_RAISE:   raise_r = data[RATIO_W-1:0];
				REG_LOWER:   lower_r = data[RATIO_W-1:0];
				default: ;
			endcase
		endfunction

		// Pull the ratio toward 1.0 when the count sits close to the far bound
		function ratio_t ease_ratio(ratio_t r, int gap, int win);
			longint delta;
			if (gap >= win)
				return r;
			delta = (longint'(ONE_Q14) - longint'(r)) * longint'(win - gap);
			delta = delta / longint'(win);
			return ratio_t'(longint'(r) + delta);
		endfunction

		// Q16.16 times Q2.14, reduced per variant with saturation
		function thr_t scale_threshold(thr_t t, ratio_t r, var_t v);
			logic [63:0] p;
			logic [63:0] q;
			thr_t res;
			p = 64'(t) * 64'(r);
			if (v == VAR_FRAC) begin
				q = p >> 14;
				res = (q > 64'hFFFF_FFFF) ? SAT_FRAC : q[31:0];
			end else begin
				if (v == VAR_ROUND)
					q = (p + (64'd1 << 29)) >> 30;
				else
					q = p >> 30;
				res = (q > 64'hFFFF) ? SAT_INT : {q[15:0], 16'h0000};
			end
			return res;
		endfunction

		// One accepted count beat: update the threshold and queue the expected result
		function void tune_step(count_t cnt);
			var_t   v;
			ratio_t r;
			int     gap;
			verd_t  vd;
			logic   fin;
			attempt_result_t e;
			v = (variant == VAR_SPARE) ? VAR_TRUNC : variant;
			if (cnt < min_cnt) begin
				vd = VERD_TOO_FEW;
				r = lower_r;
				if (v == VAR_ROUND) begin
					gap = int'(cnt) - int'(max_cnt);
					if (gap < 0)
						gap = -gap;
					r = ease_ratio(r, gap, int'(WIN_TOO_FEW));
				end
				cur_thr = scale_threshold(cur_thr, r, v);
				if (cur_thr < floor_thr)
					cur_thr = floor_thr;
			end else if (cnt > max_cnt) begin
				vd = VERD_TOO_MANY;
				r = raise_r;
				if (v == VAR_ROUND) begin
					gap = int'(cnt) - int'(min_cnt);
					if (gap < 0)
						gap = -gap;
					r = ease_ratio(r, gap, int'(WIN_TOO_MANY));
				end
				cur_thr = scale_threshold(cur_thr, r, v);
				if (cur_thr > ceil_thr)
					cur_thr = ceil_thr;
			end else begin
				vd = VERD_IN_RANGE;
			end
			fin = (vd == VERD_IN_RANGE) || (int'(attempt) + 1 >= RETRY_LIMIT);
			e = '{cur_thr, vd, fin, attempt};
			pending_results = {pending_results, e};
			attempt = fin ? att_t'(0) : att_t'(attempt + 1);
		endfunction

		task check_result(thr_t thr, verd_t vd, logic fin, att_t idx);
			attempt_result_t e;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
				return;
			end
			e = pending_results.pop_front();
			if (thr !== e.thr)
				report_mismatch($sformatf("next_threshold %h, want %h", thr, e.thr));
			if (vd !== e.verd)
				report_mismatch($sformatf("verdict %0d, want %0d", vd, e.verd));
			if (fin !== e.fin)
				report_mismatch($sformatf("finished %0b, want %0b", fin, e.fin));
			if (idx !== e.idx)
				report_mismatch($sformatf("attempt_index %0d, want %0d", idx, e.idx));
		endtask
	endclass

	logic   clk;
	logic   arst_n;
	logic   cfg_wr_en;
	idx_t   cfg_index;
	thr_t   cfg_data;
	logic   in_valid;
	logic   in_stall;
	count_t keypoint_count;
	logic   out_valid;
	logic   out_stall;
	thr_t   next_threshold;
	verd_t  verdict;
	logic   finished;
	att_t   attempt_index;

	threshold_scoreboard sb;
	tune_setting_t cur_set;
	bit calm;
	bit hold_long;

	feature_threshold_autotune DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.keypoint_count(keypoint_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_threshold(next_threshold),
		.verdict       (verdict),
		.finished      (finished),
		.attempt_index (attempt_index)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#1000000;
		$display("tb_feature_threshold_autotune failed");
		$finish;
	end

	// Result side: random stall bursts, one long hold on request, none when calm
	initial begin
		int left;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				left = LONG_HOLD;
			end else if (left == 0 && !calm && $urandom_range(0, 3) == 0) begin
				left = $urandom_range(1, 4);
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Observe writes and both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.write_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				sb.check_result(next_threshold, verdict, finished, attempt_index);
			if (in_valid && !in_stall)
				sb.tune_step(keypoint_count);
		end
	end

	// Leaves the write enable high; end_writes lowers it after a batch
	task write_reg(idx_t idx, thr_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task end_writes();
		cfg_wr_en <= 1'b0;
	endtask

	// Narrow registers get junk in the unused upper data bits
	task apply_setting(tune_setting_t s);
		cur_set = s;
		write_reg(REG_VARIANT, {30'($urandom), s.variant});
		write_reg(REG_MIN, {16'($urandom), s.min_cnt});
		write_reg(REG_MAX, {16'($urandom), s.max_cnt});
		write_reg(REG_FLOOR, s.floor_thr);
		write_reg(REG_START, s.start_thr);
		write_reg(REG_CEIL, s.ceil_thr);
		write_reg(REG_RAISE, {16'($urandom), s.raise_r});
		write_reg(REG_LOWER, {16'($urandom), s.lower_r});
		end_writes();
	endtask

	// Offer one count beat, hold it until taken, then maybe idle a short burst
	task feed(count_t cnt);
		keypoint_count <= cnt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task wait_drained();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task feed_list(count_t cnts[$]);
		foreach (cnts[i])
			feed(cnts[i]);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	function automatic tune_setting_t rand_setting();
		tune_setting_t s;
		s.variant = var_t'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				s.min_cnt = count_t'($urandom_range(100, 3000));
				s.max_cnt = count_t'(s.min_cnt + $urandom_range(0, 1200));
			end
			3: begin
				s.min_cnt = '1;
				s.max_cnt = '0;
			end
			4: begin
				s.min_cnt = '0;
				s.max_cnt = count_t'($urandom_range(0, 800));
			end
			default: begin
				s.min_cnt = count_t'($urandom);
				s.max_cnt = count_t'($urandom);
			end
		endcase
		case ($urandom_range(0, 4))
			0, 1, 2: begin
				s.floor_thr = $urandom_range(0, 32'h0020_0000);
				s.ceil_thr = s.floor_thr + $urandom_range(32'h0001_0000, 32'h0800_0000);
			end
			3: begin
				s.floor_thr = '0;
				s.ceil_thr = '1;
			end
			default: begin
				s.floor_thr = $urandom;
				s.ceil_thr = $urandom;
			end
		endcase
		case ($urandom_range(0, 3))
			0, 1: s.start_thr = $urandom_range(s.floor_thr, s.ceil_thr);
			2: s.start_thr = $urandom;
			default: s.start_thr = $urandom_range(0, 1) ? '1 : '0;
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: s.raise_r = ratio_t'($urandom_range(16384, 40000));
			3: s.raise_r = '1;
			4: s.raise_r = '0;
			default: s.raise_r = ratio_t'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: s.lower_r = ratio_t'($urandom_range(2000, 16384));
			3: s.lower_r = '0;
			4: s.lower_r = '1;
			default: s.lower_r = ratio_t'($urandom);
		endcase
		return s;
	endfunction

	// Counts cluster around the bounds so the near-bound windows get hit
	function automatic count_t pick_count(tune_setting_t s);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = int'(s.min_cnt) - int'($urandom_range(1, 1100));
			3, 4, 5: v = int'(s.max_cnt) + int'($urandom_range(1, 600));
			6, 7: v = int'($urandom_range(s.min_cnt, s.max_cnt));
			default: v = int'($urandom_range(0, 65535));
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return count_t'(v);
	endfunction

	initial begin
		tune_setting_t s;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		keypoint_count = '0;
		calm = 1'b0;
		hold_long = 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: both bounds, their neighbors, in range, then retries used up
		feed_list('{16'd0, 16'd65535, 16'd1000, 16'd5000, 16'd999, 16'd5001, 16'd3000,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535});

		// Keep-fraction variant: overflow saturates, zero ratio falls to the floor
		s = '{VAR_FRAC, 16'd1000, 16'd5000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'h0000};
		apply_setting(s);
		feed_list('{16'd65535, 16'd0});

		// Rounding variant: floor above ceiling, counts inside both windows
		s = '{VAR_ROUND, 16'd1000, 16'd1400, 32'h0010_0000, 32'hFFFF_0000, 32'h0000_8000,
			16'hFFFF, 16'd8192};
		apply_setting(s);
		feed_list('{16'd65535, 16'd999, 16'd1401, 16'd1200});

		// Unused selector with a zero threshold and inverted count bounds
		s = '{VAR_SPARE, 16'hFFFF, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF};
		apply_setting(s);
		feed_list('{16'd0, 16'd65535});

		// Start reload mid-image keeps the attempt counter
		write_reg(REG_START, 32'h0040_0000);
		end_writes();
		feed_list('{16'd0, 16'd0});

		// Random phases; the last two run without idling
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph >= 6);
			apply_setting(rand_setting());
			for (int k = 0; k < 55; k++) begin
				if (ph == 1 && k == 10)
					hold_long = 1'b1;
				if (ph == 3 && k == 30) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				feed(pick_count(cur_set));
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (120) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("tb_feature_threshold_autotune passed");
		else
			$display("tb_feature_threshold_autotune failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/ftat_pkg.sv
rtl/ftat_serial_mul.sv
rtl/ftat_serial_div.sv
rtl/feature_threshold_autotune.sv
tb/tb_feature_threshold_autotune.sv
